// ----- sv/mm4_pkg.sv -----
// shared types and constants for the 4x4 fixed-point matrix multiplier
package mm4_pkg;

  localparam int unsigned ELEM_W = 16;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned SUM_W  = 34;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned OUT_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  typedef struct packed {
    logic a_we;
    logic b_we;
  } cell_wr_t;

endpackage

// ----- sv/mm4_cell.sv -----
// one chain cell: holds column k of A and row k of B, adds one product per beat
module mm4_cell import mm4_pkg::*; #(
  parameter int unsigned DIM   = 4,
  parameter int unsigned IDX_W = 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_wr_t                wr_i,
  input  logic [IDX_W-1:0]        wr_addr_i,
  input  logic signed [ELEM_W-1:0] wr_data_i,
  input  logic                    in_valid_i,
  input  logic [IDX_W-1:0]        in_row_i,
  input  logic [IDX_W-1:0]        in_col_i,
  input  logic signed [SUM_W-1:0] in_sum_i,
  output logic                    out_valid_o,
  output logic [IDX_W-1:0]        out_row_o,
  output logic [IDX_W-1:0]        out_col_o,
  output logic signed [SUM_W-1:0] out_sum_o
);

  logic signed [ELEM_W-1:0] a_col_q [DIM];
  logic signed [ELEM_W-1:0] b_row_q [DIM];
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum_d;
  logic                     valid_q;
  logic [IDX_W-1:0]         row_q, col_q;
  logic signed [SUM_W-1:0]  sum_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.a_we) begin
      a_col_q[wr_addr_i] <= wr_data_i;
    end
    if (wr_i.b_we) begin
      b_row_q[wr_addr_i] <= wr_data_i;
    end
  end

  // A[row][k] * B[k][col], sign extended into the running sum
  assign prod  = a_col_q[in_row_i] * b_row_q[in_col_i];
  assign sum_d = in_sum_i + SUM_W'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= in_row_i;
    col_q <= in_col_i;
    sum_q <= sum_d;
  end

  assign out_valid_o = valid_q;
  assign out_row_o   = row_q;
  assign out_col_o   = col_q;
  assign out_sum_o   = sum_q;

endmodule

// ----- sv/matrix_multiply_4x4.sv -----
// top level: loads A and B element by element, streams out A times B in row-major order
//
// Commands enter on start_i while busy_o is low, one beat per accepted cycle.
// opcode_i selects: write an element of A, write an element of B, or compute.
// A write gives no result; writes with a row or column
// outside the matrix and the unused opcode are dropped.
// A compute issues one product entry per cycle into a chain of DIM cells;
// cell k adds A[i][k]*B[k][j] and hands the partial sum on through its
// registered output; after the issue register and the DIM cells, the DIM*DIM
// entries follow one per cycle, the final one marked by last_entry_o.
// Each result is shown for exactly one cycle with result_valid_o high; the
// receiver cannot stall it. busy_o stays high while the sequencer issues and
// while any beat has yet to enter a cell of the chain, so a compute occupies
// the block through its issue and the drain of the chain.
// product_value_o is the exact Q18.16 sum (wrapping modulo 2^34 only for DIM > 7).
// Reset clears the sequencer and the chain valids; matrix contents are not
// cleared and must be written before they are used.
module matrix_multiply_4x4 import mm4_pkg::*; #(
  parameter int unsigned DIM = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic [1:0]               row_index_i,
  input  logic [1:0]               col_index_i,
  input  logic signed [ELEM_W-1:0] element_value_i,
  output logic                     result_valid_o,
  output logic [OUT_IDX_W-1:0]     out_row_o,
  output logic [OUT_IDX_W-1:0]     out_col_o,
  output logic signed [SUM_W-1:0]  product_value_o,
  output logic                     last_entry_o
);

  localparam int unsigned IDX_W = (DIM > 1) ? $clog2(DIM) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

  logic                    accept;
  logic                    in_range;
  logic [31:0]             row_ext, col_ext;
  logic                    wr_a, wr_b;
  logic [IDX_W-1:0]        wr_addr;

  logic                    issue_q;
  logic [IDX_W-1:0]        row_q, col_q;

  logic [DIM:0]            chain_valid;
  logic [IDX_W-1:0]        chain_row [DIM+1];
  logic [IDX_W-1:0]        chain_col [DIM+1];
  logic signed [SUM_W-1:0] chain_sum [DIM+1];
  cell_wr_t                cell_wr [DIM];

  assign accept   = start_i && !busy_o;
  assign row_ext  = 32'(row_index_i);
  assign col_ext  = 32'(col_index_i);
  assign in_range = (row_ext < DIM) && (col_ext < DIM);
  assign wr_a     = accept && (opcode_i == OP_WRITE_A) && in_range;
  assign wr_b     = accept && (opcode_i == OP_WRITE_B) && in_range;
  // A is stored by column per cell, B by row per cell
  assign wr_addr  = wr_a ? IDX_W'(row_index_i) : IDX_W'(col_index_i);

  // issue sequencer: walks (row, col) over the product in row-major order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
    end else if (issue_q) begin
      if (col_q == IDX_LAST) begin
        col_q <= '0;
        if (row_q == IDX_LAST) begin
          row_q   <= '0;
          issue_q <= 1'b0;
        end else begin
          row_q <= row_q + 1'b1;
        end
      end else begin
        col_q <= col_q + 1'b1;
      end
    end else if (accept && (opcode_i == OP_COMPUTE)) begin
      issue_q <= 1'b1;
      row_q   <= '0;
      col_q   <= '0;
    end
  end

  assign chain_valid[0] = issue_q;
  assign chain_row[0]   = row_q;
  assign chain_col[0]   = col_q;
  assign chain_sum[0]   = '0;

  for (genvar k = 0; k < DIM; k++) begin : g_cell
    assign cell_wr[k].a_we = wr_a && (col_ext == 32'(k));
    assign cell_wr[k].b_we = wr_b && (row_ext == 32'(k));

    mm4_cell #(
      .DIM   (DIM),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_i        (cell_wr[k]),
      .wr_addr_i   (wr_addr),
      .wr_data_i   (element_value_i),
      .in_valid_i  (chain_valid[k]),
      .in_row_i    (chain_row[k]),
      .in_col_i    (chain_col[k]),
      .in_sum_i    (chain_sum[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_row_o   (chain_row[k+1]),
      .out_col_o   (chain_col[k+1]),
      .out_sum_o   (chain_sum[k+1])
    );
  end

  // stores must stay put while any beat is still inside the chain
  assign busy_o = issue_q || (|chain_valid[DIM-1:1]);

  assign result_valid_o  = chain_valid[DIM];
  assign out_row_o       = OUT_IDX_W'(chain_row[DIM]);
  assign out_col_o       = OUT_IDX_W'(chain_col[DIM]);
  assign product_value_o = chain_sum[DIM];
  assign last_entry_o    = chain_valid[DIM] && (chain_row[DIM] == IDX_LAST) &&
                           (chain_col[DIM] == IDX_LAST);

`ifndef NO_ASSERTIONS
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_entry_o |=> result_valid_o)
    else $error("product run broke before its last entry");

  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (opcode_i == OP_COMPUTE) |=> busy_o && issue_q)
    else $error("compute accepted but issue did not start");

  a_first_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q && (row_q == '0) && (col_q == '0) |-> !result_valid_o || last_entry_o)
    else $error("new run started while an old run was mid-stream");
`endif

endmodule
